// ===== hw/rtl/iopt_pkg.sv =====
package iopt_pkg;

    // request kinds; code 3 is unused and changes no state
    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_TICK  = 2'd2
    } t_req_type;

    // register map, offset bits 2..0
    localparam logic [2:0] OFS_A_DATA = 3'd0;
    localparam logic [2:0] OFS_A_DIR  = 3'd1;
    localparam logic [2:0] OFS_B_DATA = 3'd2;
    localparam logic [2:0] OFS_B_DIR  = 3'd3;
    localparam logic [2:0] OFS_TMR_LO = 3'd4;
    localparam logic [2:0] OFS_TMR_HI = 3'd6;
    localparam logic [2:0] OFS_STATUS = 3'd7;

    // prescaler select codes, offset bits 1..0
    localparam logic [1:0] PSC_DIV1    = 2'd0;
    localparam logic [1:0] PSC_DIV8    = 2'd1;
    localparam logic [1:0] PSC_DIV64   = 2'd2;
    localparam logic [1:0] PSC_DIV1024 = 2'd3;

    localparam int          PSC_W         = 10;
    localparam logic [PSC_W-1:0] PSC_LAST_1    = PSC_W'(0);
    localparam logic [PSC_W-1:0] PSC_LAST_8    = PSC_W'(8 - 1);
    localparam logic [PSC_W-1:0] PSC_LAST_64   = PSC_W'(64 - 1);
    localparam logic [PSC_W-1:0] PSC_LAST_1024 = PSC_W'(1024 - 1);

    localparam logic [7:0] STATUS_FLAG = 8'h80;
    localparam logic [7:0] IDLE_DATA   = 8'hFF;

    // one request as it leaves the input register
    typedef struct packed {
        logic       fire;
        logic [1:0] req;
        logic [3:0] offset;
        logic [7:0] data;
    } t_acc;

    // timer state seen by the read mux
    typedef struct packed {
        logic [7:0] count_rd;
        logic       expired;
        logic       irq_en;
    } t_tmr_stat;

    function automatic logic [PSC_W-1:0] prescale_last(input logic [1:0] sel);
        logic [PSC_W-1:0] last;
        case (sel)
            PSC_DIV1:  last = PSC_LAST_1;
            PSC_DIV8:  last = PSC_LAST_8;
            PSC_DIV64: last = PSC_LAST_64;
            default:   last = PSC_LAST_1024;
        endcase
        return last;
    endfunction

endpackage

// ===== hw/rtl/iopt_ports.sv =====
module iopt_ports (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  iopt_pkg::t_acc i_acc,
    output logic [7:0]    o_a_drive,
    output logic [7:0]    o_a_dir,
    output logic [7:0]    o_b_drive,
    output logic [7:0]    o_b_dir
);
    import iopt_pkg::*;

    logic [7:0] r_a_drive, r_a_dir, r_b_drive, r_b_dir;
    logic       wr_port;

    // offset bit 3 is don't-care for port registers
    assign wr_port = i_acc.fire && (i_acc.req == REQ_WRITE) && !i_acc.offset[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_drive <= '0;
            r_a_dir   <= '0;
            r_b_drive <= '0;
            r_b_dir   <= '0;
        end else if (wr_port) begin
            case (i_acc.offset[2:0])
                OFS_A_DATA: r_a_drive <= i_acc.data;
                OFS_A_DIR:  r_a_dir   <= i_acc.data;
                OFS_B_DATA: r_b_drive <= i_acc.data;
                OFS_B_DIR:  r_b_dir   <= i_acc.data;
                default: ;
            endcase
        end
    end

    assign o_a_drive = r_a_drive;
    assign o_a_dir   = r_a_dir;
    assign o_b_drive = r_b_drive;
    assign o_b_dir   = r_b_dir;

endmodule

// ===== hw/rtl/iopt_timer.sv =====
module iopt_timer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iopt_pkg::t_acc     i_acc,
    output iopt_pkg::t_tmr_stat o_stat
);
    import iopt_pkg::*;

    logic             r_running, n_running;
    logic             r_expired, n_expired;
    logic             r_irq_en,  n_irq_en;
    logic [7:0]       r_count,   n_count;
    logic [7:0]       r_reload,  n_reload;
    logic [PSC_W-1:0] r_pre,     n_pre;
    logic [1:0]       r_sel,     n_sel;
    logic             tmr_ofs;

    assign tmr_ofs = i_acc.offset[2];

    always_comb begin
        n_running = r_running;
        n_expired = r_expired;
        n_irq_en  = r_irq_en;
        n_count   = r_count;
        n_reload  = r_reload;
        n_pre     = r_pre;
        n_sel     = r_sel;
        if (i_acc.fire) begin
            if (i_acc.req == REQ_READ && tmr_ofs) begin
                // any timer read latches irq enable; status read also acks
                n_irq_en = i_acc.offset[3];
                if (i_acc.offset[2:0] == OFS_STATUS) begin
                    n_expired = 1'b0;
                end
            end else if (i_acc.req == REQ_WRITE && tmr_ofs) begin
                n_expired = 1'b0;
                n_irq_en  = i_acc.offset[3];
                n_count   = i_acc.data;
                n_reload  = i_acc.data;
                n_sel     = i_acc.offset[1:0];
                n_pre     = '0;
                n_running = 1'b1;
            end else if (i_acc.req == REQ_TICK && r_running) begin
                if (r_pre >= prescale_last(r_sel)) begin
                    n_pre = '0;
                    if (r_count == '0) begin
                        n_expired = 1'b1;
                        n_count   = r_reload;
                    end else begin
                        n_count = r_count - 8'd1;
                    end
                end else begin
                    n_pre = r_pre + PSC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_expired <= 1'b0;
            r_irq_en  <= 1'b0;
            r_count   <= '0;
            r_reload  <= '0;
            r_pre     <= '0;
            r_sel     <= PSC_DIV1;
        end else begin
            r_running <= n_running;
            r_expired <= n_expired;
            r_irq_en  <= n_irq_en;
            r_count   <= n_count;
            r_reload  <= n_reload;
            r_pre     <= n_pre;
            r_sel     <= n_sel;
        end
    end

    // count reads as zero until the timer is first loaded
    assign o_stat.count_rd = r_running ? r_count : 8'd0;
    assign o_stat.expired  = r_expired;
    assign o_stat.irq_en   = r_irq_en;

endmodule

// ===== hw/rtl/io_ports_interval_timer.sv =====
// Channel   Direction  Handshake                 Payload
// request   in         i_in_valid / o_in_stall   i_req_type, i_reg_offset, i_write_data,
//                                                i_port_a_pins, i_port_b_pins
// result    out        o_out_valid / i_out_stall o_read_data, o_port_a_drive, o_port_a_dir,
//                                                o_port_b_drive, o_port_b_dir, o_irq
//
// One request per cycle sustained while the result is not stalled; a request passes the
// input register, then the result register, before its result is valid.
// Reset (i_rst_n low, synchronous) clears ports, timer and both pipeline valids.
// A held result stalls the execute step; the input register keeps taking a request
// while it is empty or its content moves on in the same cycle.
module io_ports_interval_timer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [3:0] i_reg_offset,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_port_a_pins,
    input  logic [7:0] i_port_b_pins,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic [7:0] o_port_a_drive,
    output logic [7:0] o_port_a_dir,
    output logic [7:0] o_port_b_drive,
    output logic [7:0] o_port_b_dir,
    output logic       o_irq
);
    import iopt_pkg::*;

    // input register
    logic       r_in_vld;
    logic [1:0] r_req;
    logic [3:0] r_off;
    logic [7:0] r_data, r_pa, r_pb;

    // result register
    logic       r_out_vld;
    logic [7:0] r_rd_data, n_rd_data;

    logic       fire;       // request executes this cycle
    logic       in_take;    // input register loads
    t_acc       acc;
    t_tmr_stat  tmr_stat;
    logic [7:0] a_drive, a_dir, b_drive, b_dir;

    // execute when a request is waiting and the result slot is free or draining
    assign fire    = r_in_vld && !(r_out_vld && i_out_stall);
    assign in_take = !r_in_vld || fire;
    assign o_in_stall = !in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_req  <= i_req_type;
            r_off  <= i_reg_offset;
            r_data <= i_write_data;
            r_pa   <= i_port_a_pins;
            r_pb   <= i_port_b_pins;
        end
    end

    assign acc.fire   = fire;
    assign acc.req    = r_req;
    assign acc.offset = r_off;
    assign acc.data   = r_data;

    iopt_ports u_ports (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .o_a_drive (a_drive),
        .o_a_dir   (a_dir),
        .o_b_drive (b_drive),
        .o_b_dir   (b_dir)
    );

    iopt_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .o_stat  (tmr_stat)
    );

    // read mux sees state before this request's update
    always_comb begin
        n_rd_data = IDLE_DATA;
        if (r_req == REQ_READ) begin
            case (r_off[2:0])
                OFS_A_DATA: n_rd_data = (r_pa & ~a_dir) | (a_drive & a_dir);
                OFS_A_DIR:  n_rd_data = a_dir;
                OFS_B_DATA: n_rd_data = (r_pb & ~b_dir) | (b_drive & b_dir);
                OFS_B_DIR:  n_rd_data = b_dir;
                OFS_STATUS: n_rd_data = tmr_stat.expired ? STATUS_FLAG : 8'h00;
                default:    n_rd_data = tmr_stat.count_rd;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rd_data <= n_rd_data;
        end
    end

    // State only changes on fire, which also loads the result register, so the
    // live state always matches the held result's post-request values.
    assign o_out_valid    = r_out_vld;
    assign o_read_data    = r_rd_data;
    assign o_port_a_drive = a_drive;
    assign o_port_a_dir   = a_dir;
    assign o_port_b_drive = b_drive;
    assign o_port_b_dir   = b_dir;
    assign o_irq          = tmr_stat.expired && tmr_stat.irq_en;

    // executed request always shows up as a result next cycle
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("executed request produced no result");

    // timer load drops the interrupt
    a_load_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_req == REQ_WRITE && r_off[2]) |=> !o_irq)
        else $error("irq still set after timer load");

    // status read acknowledges the flag
    a_stat_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_req == REQ_READ && r_off[2:0] == OFS_STATUS) |=> !o_irq)
        else $error("irq still set after status read");

    // no new state while a result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_irq) && $stable(o_port_a_dir))
        else $error("state moved under a held result");

endmodule
